>>> sv/lfu_name_address_cache_defines.svh
// Assertion macros shared by the name address cache RTL.
`ifndef LFU_NAME_ADDRESS_CACHE_DEFINES_SVH
`define LFU_NAME_ADDRESS_CACHE_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define LFU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An implication checked in the same cycle outside reset.
`define LFU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> sv/lfu_pkg.sv
// Shared types and constants of the name address cache.
`default_nettype none

package lfu_pkg;

  localparam int unsigned OpW     = 2;
  localparam int unsigned KeyW    = 64;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned CntW    = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned SlotW   = 3;
  localparam int unsigned MaxIdxW = 6;

  typedef enum logic [OpW-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_RSVD   = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_MISS     = 3'd0,
    ST_HIT      = 3'd1,
    ST_PRESENT  = 3'd2,
    ST_FILLED   = 3'd3,
    ST_REPLACED = 3'd4,
    ST_CLEARED  = 3'd5
  } status_e;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [AddrW-1:0] addr;
    logic [CntW-1:0]  cnt;
  } entry_t;

  typedef struct packed {
    logic               rd_en;
    logic [MaxIdxW-1:0] rd_idx;
    logic               wr_en;
    logic [MaxIdxW-1:0] wr_idx;
    entry_t             wr_ent;
  } mem_req_t;

endpackage

`default_nettype wire

>>> sv/lfu_ifs.sv
// Valid/ready channel interfaces for request and response words.
`default_nettype none

interface lfu_in_if;
  logic                        valid;
  logic                        ready;
  logic [lfu_pkg::OpW-1:0]     op;
  logic [lfu_pkg::KeyW-1:0]    name_key;
  logic [lfu_pkg::AddrW-1:0]   addr_in;

  modport source (output valid, op, name_key, addr_in, input ready);
  modport sink   (input valid, op, name_key, addr_in, output ready);
endinterface

interface lfu_out_if;
  logic                        valid;
  logic                        ready;
  logic [lfu_pkg::StatusW-1:0] status;
  logic [lfu_pkg::AddrW-1:0]   addr_out;
  logic [lfu_pkg::SlotW-1:0]   slot;

  modport source (output valid, status, addr_out, slot, input ready);
  modport sink   (input valid, status, addr_out, slot, output ready);
endinterface

`default_nettype wire

>>> sv/lfu_mem.sv
// Entry memory: one write port and one registered read port.
`default_nettype none

module lfu_mem #(
  parameter int unsigned ENTRIES = 8
) (
  input  wire logic              clk_i,
  input  wire lfu_pkg::mem_req_t req_i,
  output lfu_pkg::entry_t        rd_ent_o
);

  localparam int unsigned IdxW = $clog2(ENTRIES);

  lfu_pkg::entry_t mem_q [ENTRIES];
  lfu_pkg::entry_t rd_ent_q;

  // Synchronous write and read; read data is registered and appears in the cycle after the read.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_idx[IdxW-1:0]] <= req_i.wr_ent;
    end
    if (req_i.rd_en) begin
      rd_ent_q <= mem_q[req_i.rd_idx[IdxW-1:0]];
    end
  end

  assign rd_ent_o = rd_ent_q;

endmodule

`default_nettype wire

>>> sv/lfu_ctrl.sv
// Sequencer that scans the entry memory, picks hits and victims, and writes back.
`default_nettype none

`include "lfu_name_address_cache_defines.svh"

module lfu_ctrl #(
  parameter int unsigned ENTRIES = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  lfu_in_if.sink                 in_i,
  lfu_out_if.source              out_o,
  output lfu_pkg::mem_req_t      mem_req_o,
  input  wire lfu_pkg::entry_t   mem_ent_i
);

  localparam int unsigned IdxW  = $clog2(ENTRIES);
  localparam int unsigned FillW = $clog2(ENTRIES + 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_WRITE  = 5'b01000,
    S_RESP   = 5'b10000
  } state_e;

  state_e                       state_q, state_d;
  logic [FillW-1:0]             fill_q, fill_d;
  logic [FillW-1:0]             issue_q, issue_d;
  logic                         dvld_q, dvld_d;
  logic                         out_vld_q, out_vld_d;

  lfu_pkg::op_e                 op_q, op_d;
  logic [lfu_pkg::KeyW-1:0]     key_q, key_d;
  logic [lfu_pkg::AddrW-1:0]    addr_q, addr_d;
  logic [IdxW-1:0]              didx_q, didx_d;
  logic [lfu_pkg::CntW-1:0]     best_cnt_q, best_cnt_d;
  logic [IdxW-1:0]              best_idx_q, best_idx_d;
  logic [IdxW-1:0]              wr_idx_q, wr_idx_d;
  lfu_pkg::entry_t              wr_ent_q, wr_ent_d;
  lfu_pkg::status_e             res_status_q, res_status_d;
  logic [lfu_pkg::AddrW-1:0]    res_addr_q, res_addr_d;
  logic [lfu_pkg::SlotW-1:0]    res_slot_q, res_slot_d;
  lfu_pkg::status_e             out_status_q, out_status_d;
  logic [lfu_pkg::AddrW-1:0]    out_addr_q, out_addr_d;
  logic [lfu_pkg::SlotW-1:0]    out_slot_q, out_slot_d;

  logic                         rd_en;
  logic                         key_hit;
  logic                         pair_hit;
  logic                         last_data;
  logic                         out_free;

  // Read one entry per scan cycle while entries remain.
  assign rd_en     = (state_q == S_SCAN) && (issue_q < fill_q);
  assign key_hit   = (mem_ent_i.key == key_q);
  assign pair_hit  = key_hit && (mem_ent_i.addr == addr_q);
  assign last_data = ((FillW'(didx_q) + FillW'(1)) == fill_q);
  assign out_free  = !out_vld_q || out_o.ready;

  always_comb begin
    mem_req_o        = '0;
    mem_req_o.rd_en  = rd_en;
    mem_req_o.rd_idx = lfu_pkg::MaxIdxW'(issue_q[IdxW-1:0]);
    mem_req_o.wr_en  = (state_q == S_WRITE);
    mem_req_o.wr_idx = lfu_pkg::MaxIdxW'(wr_idx_q);
    mem_req_o.wr_ent = wr_ent_q;
  end

  assign in_i.ready = (state_q == S_IDLE);

  // Sequencer and result formation.
  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    issue_d      = issue_q;
    dvld_d       = dvld_q;
    out_vld_d    = out_vld_q;
    op_d         = op_q;
    key_d        = key_q;
    addr_d       = addr_q;
    didx_d       = didx_q;
    best_cnt_d   = best_cnt_q;
    best_idx_d   = best_idx_q;
    wr_idx_d     = wr_idx_q;
    wr_ent_d     = wr_ent_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    res_slot_d   = res_slot_q;
    out_status_d = out_status_q;
    out_addr_d   = out_addr_q;
    out_slot_d   = out_slot_q;

    // The output word leaves when the sink takes it.
    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d         = lfu_pkg::op_e'(in_i.op);
          key_d        = in_i.name_key;
          addr_d       = in_i.addr_in;
          issue_d      = '0;
          dvld_d       = 1'b0;
          res_status_d = lfu_pkg::ST_MISS;
          res_addr_d   = '0;
          res_slot_d   = '0;
          unique case (lfu_pkg::op_e'(in_i.op))
            lfu_pkg::OP_CLEAR: begin
              fill_d       = '0;
              res_status_d = lfu_pkg::ST_CLEARED;
              state_d      = S_RESP;
            end
            lfu_pkg::OP_RSVD: begin
              state_d = S_RESP;
            end
            lfu_pkg::OP_LOOKUP, lfu_pkg::OP_INSERT: begin
              state_d = (fill_q == '0) ? S_DECIDE : S_SCAN;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_SCAN: begin
        dvld_d = rd_en;
        if (rd_en) begin
          issue_d = issue_q + FillW'(1);
          didx_d  = issue_q[IdxW-1:0];
        end
        if (dvld_q) begin
          // Track the first entry with the least count.
          if ((didx_q == '0) || (mem_ent_i.cnt < best_cnt_q)) begin
            best_cnt_d = mem_ent_i.cnt;
            best_idx_d = didx_q;
          end
          if ((op_q == lfu_pkg::OP_LOOKUP) && key_hit) begin
            wr_idx_d      = didx_q;
            wr_ent_d      = mem_ent_i;
            wr_ent_d.cnt  = (mem_ent_i.cnt == '1) ? mem_ent_i.cnt
                                                  : mem_ent_i.cnt + lfu_pkg::CntW'(1);
            res_status_d  = lfu_pkg::ST_HIT;
            res_addr_d    = mem_ent_i.addr;
            res_slot_d    = lfu_pkg::SlotW'(didx_q);
            state_d       = S_WRITE;
          end else if ((op_q == lfu_pkg::OP_INSERT) && pair_hit) begin
            res_status_d  = lfu_pkg::ST_PRESENT;
            res_slot_d    = lfu_pkg::SlotW'(didx_q);
            state_d       = S_RESP;
          end else if (last_data) begin
            state_d       = S_DECIDE;
          end
        end
      end

      S_DECIDE: begin
        if (op_q == lfu_pkg::OP_INSERT) begin
          wr_ent_d.key  = key_q;
          wr_ent_d.addr = addr_q;
          wr_ent_d.cnt  = '0;
          if (fill_q < FillW'(ENTRIES)) begin
            wr_idx_d     = fill_q[IdxW-1:0];
            fill_d       = fill_q + FillW'(1);
            res_status_d = lfu_pkg::ST_FILLED;
            res_slot_d   = lfu_pkg::SlotW'(fill_q[IdxW-1:0]);
          end else begin
            wr_idx_d     = best_idx_q;
            res_status_d = lfu_pkg::ST_REPLACED;
            res_slot_d   = lfu_pkg::SlotW'(best_idx_q);
          end
          state_d = S_WRITE;
        end else begin
          res_status_d = lfu_pkg::ST_MISS;
          res_addr_d   = '0;
          res_slot_d   = '0;
          state_d      = S_RESP;
        end
      end

      S_WRITE: begin
        state_d = S_RESP;
      end

      S_RESP: begin
        if (out_free) begin
          out_vld_d    = 1'b1;
          out_status_d = res_status_q;
          out_addr_d   = res_addr_q;
          out_slot_d   = res_slot_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fill_q    <= '0;
      issue_q   <= '0;
      dvld_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      issue_q   <= issue_d;
      dvld_q    <= dvld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    addr_q       <= addr_d;
    didx_q       <= didx_d;
    best_cnt_q   <= best_cnt_d;
    best_idx_q   <= best_idx_d;
    wr_idx_q     <= wr_idx_d;
    wr_ent_q     <= wr_ent_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    res_slot_q   <= res_slot_d;
    out_status_q <= out_status_d;
    out_addr_q   <= out_addr_d;
    out_slot_q   <= out_slot_d;
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.status   = out_status_q;
  assign out_o.addr_out = out_addr_q;
  assign out_o.slot     = out_slot_q;

  // The fill count never exceeds the number of entries.
  `LFU_ASSERT(a_fill_bound, fill_q <= FillW'(ENTRIES), "fill count above entry count")
  // Every write lands inside the filled region.
  `LFU_ASSERT_IMP(a_wr_in_fill, state_q == S_WRITE, FillW'(wr_idx_q) < fill_q,
                  "write beyond filled entries")
  // Returned read data always belongs to a filled entry.
  `LFU_ASSERT_IMP(a_rd_in_fill, (state_q == S_SCAN) && dvld_q, FillW'(didx_q) < fill_q,
                  "scan read beyond filled entries")
  // A cleared result leaves the cache empty.
  `LFU_ASSERT_IMP(a_clear_empty, (state_q == S_RESP) && (res_status_q == lfu_pkg::ST_CLEARED),
                  fill_q == '0, "clear left entries behind")

endmodule

`default_nettype wire

>>> sv/lfu_name_address_cache.sv
// Top level of the LFU name-to-address cache.
`default_nettype none

// Fully associative cache that maps a 64-bit name key to a 32-bit address, with
// a saturating hit count per entry and least-count replacement when full. One
// request word is handled at a time; a new request is accepted while the previous
// response word still waits at the output. The entries sit in a single memory
// with one read port, scanned one entry per cycle. A lookup hit writes back its
// raised count; a lookup miss or a new insert passes a decide step, and an insert
// then writes its entry. Clear or an unused op code goes straight to the response.
module lfu_name_address_cache #(
  parameter int unsigned ENTRIES = 8
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lfu_in_if.sink    in_i,
  lfu_out_if.source out_o
);

  lfu_pkg::mem_req_t mem_req;
  lfu_pkg::entry_t   mem_ent;

  lfu_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .out_o     (out_o),
    .mem_req_o (mem_req),
    .mem_ent_i (mem_ent)
  );

  lfu_mem #(
    .ENTRIES (ENTRIES)
  ) u_mem (
    .clk_i    (clk_i),
    .req_i    (mem_req),
    .rd_ent_o (mem_ent)
  );

endmodule

`default_nettype wire
